// ----- rtl/assert_macros.svh -----
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GMBS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gmbs assertion failed");
`define GMBS_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("gmbs forbidden condition");
`else
`define GMBS_ASSERT(lbl, clk, rstn, prop)
`define GMBS_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- rtl/gmbs_pkg.sv -----
package gmbs_pkg;

  localparam int PIXELS     = 65536;
  localparam int PIX_AW     = $clog2(PIXELS);
  localparam int COMPONENTS = 4;
  localparam int COMP_W     = $clog2(COMPONENTS);
  localparam int ENTRY_W    = 48;
  localparam int ROW_W      = ENTRY_W * COMPONENTS;
  localparam int SUM_W      = 16 + COMP_W;
  localparam int BACC_W     = 32 + COMP_W;
  localparam int ACC_W      = 50;

  localparam logic [15:0] LFSR_RESET = 16'hACE1;
  localparam logic [15:0] LFSR_MASK  = 16'hB400;
  localparam logic [16:0] Q_ONE      = 17'h10000;
  localparam logic [15:0] WT_INIT    = 16'(65536 / COMPONENTS);

  localparam logic [15:0] ALPHA_RST    = 16'd655;
  localparam logic [11:0] DFAC_RST     = 12'd640;
  localparam logic [15:0] FRAC_RST     = 16'd45875;
  localparam logic [15:0] INIT_DEV_RST = 16'd1536;

  typedef enum logic [1:0] {
    REG_ALPHA,
    REG_MATCH,
    REG_FRACTION,
    REG_INIT_DEV
  } cfg_reg_e;

  typedef enum logic {
    ITER_DIV,
    ITER_SQRT
  } iter_mode_e;

  typedef struct packed {
    logic        start;
    iter_mode_e  mode;
    logic [31:0] num;
    logic [17:0] den;
  } iter_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] res;
  } iter_rsp_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [11:0] dfac;
    logic [15:0] frac;
    logic [15:0] init_dev;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        pix;
    logic [PIX_AW-1:0] idx;
    logic              first;
  } item_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    return s[0] ? ({1'b0, s[15:1]} ^ LFSR_MASK) : {1'b0, s[15:1]};
  endfunction

  function automatic logic [15:0] dev_floor(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- rtl/gmbs_ram.sv -----
module gmbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gmbs_iter.sv -----
module gmbs_iter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gmbs_pkg::iter_req_t req_i,
  output gmbs_pkg::iter_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  gmbs_pkg::iter_mode_e mode_q;
  logic [3:0]           cnt_q;
  logic [19:0]          rem_q;
  logic [15:0]          quo_q;
  logic [31:0]          rad_q;
  logic [17:0]          den_q;
  logic [19:0]          sh, trial;
  logic                 take;

  always_comb begin
    if (mode_q == gmbs_pkg::ITER_DIV) begin
      sh    = {rem_q[18:0], 1'b0};
      trial = {2'b00, den_q};
    end else begin
      sh    = {rem_q[17:0], rad_q[31:30]};
      trial = {2'b00, quo_q, 2'b01};
    end
    take = (sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= gmbs_pkg::ITER_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        mode_q <= req_i.mode;
        cnt_q  <= 4'd15;
        rem_q  <= (req_i.mode == gmbs_pkg::ITER_DIV) ? {2'b00, req_i.num[17:0]} : 20'd0;
        rad_q  <= req_i.num;
        den_q  <= req_i.den;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= take ? (sh - trial) : sh;
        quo_q <= {quo_q[14:0], take};
        rad_q <= {rad_q[29:0], 2'b00};
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = quo_q;

endmodule

// ----- rtl/gmbs_front.sv -----
module gmbs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    pixel_value_i,
  input  logic [gmbs_pkg::PIX_AW-1:0]   pixel_index_i,
  output logic                          q_valid_o,
  output gmbs_pkg::item_t               q_item_o,
  input  logic                          q_pop_i
);

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);

  logic                        clr_busy_q;
  logic [gmbs_pkg::PIX_AW-1:0] clr_cnt_q;
  logic                        stg_v_q;
  logic [7:0]                  stg_pix_q;
  logic [gmbs_pkg::PIX_AW-1:0] stg_idx_q;
  gmbs_pkg::item_t             fifo_q [QDEPTH];
  logic [QPW-1:0]              rd_ptr_q, wr_ptr_q;
  logic [QPW:0]                cnt_q;
  logic                        accept, push, seen_rd;
  logic                        seen_we, seen_wd;
  logic [gmbs_pkg::PIX_AW-1:0] seen_wa;

  assign in_stall_o = clr_busy_q | stg_v_q | (cnt_q == (QPW+1)'(QDEPTH));
  assign accept     = in_valid_i & ~in_stall_o;
  assign push       = stg_v_q;

  assign seen_we = clr_busy_q | stg_v_q;
  assign seen_wa = clr_busy_q ? clr_cnt_q : stg_idx_q;
  assign seen_wd = ~clr_busy_q;

  gmbs_ram #(
    .WIDTH (1),
    .DEPTH (gmbs_pkg::PIXELS)
  ) u_seen (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (seen_wa),
    .wdata_i (seen_wd),
    .re_i    (accept),
    .raddr_i (pixel_index_i),
    .rdata_o (seen_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      stg_v_q    <= 1'b0;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == gmbs_pkg::PIX_AW'(gmbs_pkg::PIXELS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      stg_v_q <= accept;
      if (accept) begin
        stg_pix_q <= pixel_value_i;
        stg_idx_q <= pixel_index_i;
      end
      if (push) begin
        fifo_q[wr_ptr_q] <= '{pix: stg_pix_q, idx: stg_idx_q, first: ~seen_rd};
        wr_ptr_q         <= wr_ptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPW+1)'(push) - (QPW+1)'(q_pop_i);
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = fifo_q[rd_ptr_q];

endmodule

// ----- rtl/gmbs_back.sv -----
module gmbs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gmbs_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  gmbs_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          background_pixel_o,
  output logic                is_foreground_o,
  output logic [7:0]          foreground_pixel_o
);

  localparam int C  = gmbs_pkg::COMPONENTS;
  localparam int CW = gmbs_pkg::COMP_W;
  localparam int AW = gmbs_pkg::ACC_W;
  localparam logic [CW-1:0] LAST = CW'(C - 1);

  typedef enum logic [5:0] {
    S_IDLE, S_LOAD, S_DIFF, S_TEST, S_TEST2, S_WT, S_PDIV,
    S_M0, S_M1, S_M2, S_V0, S_V1, S_V2, S_V3, S_V4, S_V5, S_SQ, S_NEXT,
    S_MISS, S_SUM, S_NORM, S_NDIV, S_RANK, S_RMUL, S_RMUL2, S_RCMP,
    S_BG, S_BMUL, S_BTHR, S_BCHK, S_DONE
  } state_e;

  state_e                      state_q;
  logic [CW-1:0]               k_q, m_q;
  logic [7:0]                  pix_q;
  logic [gmbs_pkg::PIX_AW-1:0] idx_q;
  logic                        first_q;
  logic [15:0]                 mn_q   [C];
  logic [15:0]                 dv_q   [C];
  logic [15:0]                 wt_q   [C];
  logic [15:0]                 diff_q [C];
  logic [CW-1:0]               order_q [C];
  logic                        any_q, match_q, fg_q;
  logic [16:0]                 p_q;
  logic [15:0]                 d_q, sqhi_q, lfsr_q;
  logic [AW-1:0]               acc_q, part_q;
  logic [gmbs_pkg::SUM_W-1:0]  sum_q, cum_q;
  logic [gmbs_pkg::BACC_W-1:0] bacc_q;
  logic                        out_valid_q, out_fg_q;
  logic [7:0]                  out_bg_q, out_fp_q;

  logic [16:0]                 mul_a;
  logic [15:0]                 mul_b;
  logic                        mul_sh;
  logic [AW-1:0]               mul_base, acc_d;
  logic [32:0]                 prod;
  logic [15:0]                 x, seed_mn [C], lfsr_adv, wn, wt_lo_val;
  logic [16:0]                 wn_raw;
  logic [CW-1:0]               c, lo;
  logic [gmbs_pkg::SUM_W-1:0]  wsum;
  logic                        match_now, out_free;
  logic [gmbs_pkg::ROW_W-1:0]  row_rd, row_wd;
  gmbs_pkg::iter_req_t         iter_req;
  gmbs_pkg::iter_rsp_t         iter_rsp;

  assign x        = {pix_q, 8'h00};
  assign c        = order_q[k_q];
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign q_pop_o  = (state_q == S_IDLE) & q_valid_i;

  gmbs_ram #(
    .WIDTH (gmbs_pkg::ROW_W),
    .DEPTH (gmbs_pkg::PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_DONE) & out_free),
    .waddr_i (idx_q),
    .wdata_i (row_wd),
    .re_i    (q_pop_o),
    .raddr_i (q_item_i.idx),
    .rdata_o (row_rd)
  );

  gmbs_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .rsp_o  (iter_rsp)
  );

  always_comb begin
    for (int j = 0; j < C; j++) begin
      row_wd[j*gmbs_pkg::ENTRY_W +: gmbs_pkg::ENTRY_W] = {wt_q[j], dv_q[j], mn_q[j]};
    end
  end

  // first-visit seeds, component 0 first
  always_comb begin
    lfsr_adv = lfsr_q;
    for (int j = 0; j < C; j++) begin
      lfsr_adv   = gmbs_pkg::lfsr_step(lfsr_adv);
      seed_mn[j] = lfsr_adv;
    end
  end

  // lightest component, lowest index on ties
  always_comb begin
    lo        = '0;
    wt_lo_val = wt_q[0];
    for (int j = 1; j < C; j++) begin
      if (wt_q[j] < wt_lo_val) begin
        lo        = CW'(j);
        wt_lo_val = wt_q[j];
      end
    end
  end

  always_comb begin
    wsum = '0;
    for (int j = 0; j < C; j++) begin
      wsum = wsum + gmbs_pkg::SUM_W'(wt_q[j]);
    end
  end

  assign match_now = ({diff_q[k_q], 8'h00} < acc_q[27:0]);
  assign wn_raw    = {1'b0, wt_q[k_q]} + acc_q[32:16];
  assign wn        = wn_raw[16] ? 16'hFFFF : wn_raw[15:0];

  // shared multiply-accumulate
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sh   = 1'b0;
    mul_base = acc_q;
    unique case (state_q)
      S_TEST: begin
        mul_a = {5'b0, cfg_i.dfac}; mul_b = dv_q[k_q]; mul_base = '0;
      end
      S_TEST2: begin
        mul_base = '0;
        if (match_now) begin
          mul_a = gmbs_pkg::Q_ONE - {1'b0, wt_q[k_q]}; mul_b = cfg_i.alpha;
        end else begin
          mul_a = gmbs_pkg::Q_ONE - {1'b0, cfg_i.alpha}; mul_b = wt_q[k_q];
        end
      end
      S_M0: begin
        mul_a = gmbs_pkg::Q_ONE - p_q; mul_b = mn_q[k_q]; mul_base = '0;
      end
      S_M1: begin
        mul_a = p_q; mul_b = x;
      end
      S_M2: begin
        mul_a = {1'b0, dv_q[k_q]}; mul_b = dv_q[k_q]; mul_base = '0;
      end
      S_V0: begin
        mul_a = gmbs_pkg::Q_ONE - p_q; mul_b = acc_q[15:0]; mul_base = '0;
      end
      S_V1: begin
        mul_a = gmbs_pkg::Q_ONE - p_q; mul_b = sqhi_q; mul_sh = 1'b1;
      end
      S_V2: begin
        mul_a = {1'b0, d_q}; mul_b = d_q; mul_base = '0;
      end
      S_V3: begin
        mul_a = p_q; mul_b = acc_q[15:0]; mul_base = part_q;
      end
      S_V4: begin
        mul_a = p_q; mul_b = sqhi_q; mul_sh = 1'b1;
      end
      S_RMUL: begin
        mul_a = {1'b0, wt_q[c]}; mul_b = dv_q[order_q[m_q]]; mul_base = '0;
      end
      S_RMUL2: begin
        mul_a = {1'b0, wt_q[order_q[m_q]]}; mul_b = dv_q[c]; mul_base = '0;
      end
      S_BMUL: begin
        mul_a = {1'b0, mn_q[c]}; mul_b = wt_q[c]; mul_base = '0;
      end
      S_BTHR: begin
        mul_a = {5'b0, cfg_i.dfac}; mul_b = dv_q[c]; mul_base = '0;
      end
      default: begin
        mul_base = acc_q;
      end
    endcase
    prod  = mul_a * mul_b;
    acc_d = mul_base + (mul_sh ? {1'b0, prod, 16'h0000} : AW'(prod));
  end

  always_comb begin
    iter_req       = '0;
    iter_req.mode  = gmbs_pkg::ITER_DIV;
    if ((state_q == S_WT) && match_q && (wn != 16'd0) && (cfg_i.alpha < wn)) begin
      iter_req.start = 1'b1;
      iter_req.num   = {16'h0000, cfg_i.alpha};
      iter_req.den   = {2'b00, wn};
    end else if ((state_q == S_NORM) && (sum_q != '0) &&
                 (gmbs_pkg::SUM_W'(wt_q[k_q]) != sum_q)) begin
      iter_req.start = 1'b1;
      iter_req.num   = 32'(wt_q[k_q]);
      iter_req.den   = 18'(sum_q);
    end else if (state_q == S_V5) begin
      iter_req.start = 1'b1;
      iter_req.mode  = gmbs_pkg::ITER_SQRT;
      iter_req.num   = acc_q[47:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lfsr_q      <= gmbs_pkg::LFSR_RESET;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      m_q         <= '0;
    end else begin
      acc_q <= acc_d;
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            pix_q   <= q_item_i.pix;
            idx_q   <= q_item_i.idx;
            first_q <= q_item_i.first;
            any_q   <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int j = 0; j < C; j++) begin
            if (first_q) begin
              mn_q[j] <= seed_mn[j];
              dv_q[j] <= gmbs_pkg::dev_floor(cfg_i.init_dev);
              wt_q[j] <= gmbs_pkg::WT_INIT;
            end else begin
              mn_q[j] <= row_rd[j*gmbs_pkg::ENTRY_W +: 16];
              dv_q[j] <= row_rd[j*gmbs_pkg::ENTRY_W+16 +: 16];
              wt_q[j] <= row_rd[j*gmbs_pkg::ENTRY_W+32 +: 16];
            end
          end
          if (first_q) begin
            lfsr_q <= lfsr_adv;
          end
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          for (int j = 0; j < C; j++) begin
            diff_q[j] <= gmbs_pkg::abs_diff(x, mn_q[j]);
          end
          k_q     <= '0;
          state_q <= S_TEST;
        end
        S_TEST: state_q <= S_TEST2;
        S_TEST2: begin
          match_q <= match_now;
          state_q <= S_WT;
        end
        S_WT: begin
          if (match_q) begin
            any_q      <= 1'b1;
            wt_q[k_q]  <= wn;
            if ((wn == 16'd0) || (cfg_i.alpha >= wn)) begin
              p_q     <= gmbs_pkg::Q_ONE;
              state_q <= S_M0;
            end else begin
              state_q <= S_PDIV;
            end
          end else begin
            wt_q[k_q] <= acc_q[31:16];
            state_q   <= S_NEXT;
          end
        end
        S_PDIV: begin
          if (iter_rsp.done) begin
            p_q     <= {1'b0, iter_rsp.res};
            state_q <= S_M0;
          end
        end
        S_M0: state_q <= S_M1;
        S_M1: state_q <= S_M2;
        S_M2: begin
          mn_q[k_q] <= acc_q[31:16];
          d_q       <= gmbs_pkg::abs_diff(x, acc_q[31:16]);
          state_q   <= S_V0;
        end
        S_V0: begin
          sqhi_q  <= acc_q[31:16];
          state_q <= S_V1;
        end
        S_V1: state_q <= S_V2;
        S_V2: begin
          part_q  <= acc_q;
          state_q <= S_V3;
        end
        S_V3: begin
          sqhi_q  <= acc_q[31:16];
          state_q <= S_V4;
        end
        S_V4: state_q <= S_V5;
        S_V5: state_q <= S_SQ;
        S_SQ: begin
          if (iter_rsp.done) begin
            dv_q[k_q] <= gmbs_pkg::dev_floor(iter_rsp.res);
            state_q   <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (k_q == LAST) begin
            state_q <= S_MISS;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_TEST;
          end
        end
        S_MISS: begin
          if (!any_q) begin
            mn_q[lo] <= x;
            dv_q[lo] <= gmbs_pkg::dev_floor(cfg_i.init_dev);
          end
          state_q <= S_SUM;
        end
        S_SUM: begin
          sum_q   <= wsum;
          k_q     <= '0;
          state_q <= S_NORM;
        end
        S_NORM: begin
          if (sum_q == '0) begin
            wt_q[k_q] <= gmbs_pkg::WT_INIT;
          end else if (gmbs_pkg::SUM_W'(wt_q[k_q]) == sum_q) begin
            wt_q[k_q] <= 16'hFFFF;
          end
          if ((sum_q != '0) && (gmbs_pkg::SUM_W'(wt_q[k_q]) != sum_q)) begin
            state_q <= S_NDIV;
          end else if (k_q == LAST) begin
            state_q <= S_RANK;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_NDIV: begin
          if (iter_rsp.done) begin
            wt_q[k_q] <= iter_rsp.res;
            if (k_q == LAST) begin
              state_q <= S_RANK;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_NORM;
            end
          end
        end
        S_RANK: begin
          for (int j = 0; j < C; j++) begin
            order_q[j] <= CW'(j);
          end
          k_q     <= CW'(1);
          m_q     <= '0;
          state_q <= S_RMUL;
        end
        S_RMUL: state_q <= S_RMUL2;
        S_RMUL2: begin
          part_q  <= acc_q;
          state_q <= S_RCMP;
        end
        S_RCMP: begin
          if (part_q > acc_q) begin
            order_q[k_q] <= order_q[m_q];
            order_q[m_q] <= order_q[k_q];
          end
          if (m_q == k_q - 1'b1) begin
            m_q <= '0;
            if (k_q == LAST) begin
              state_q <= S_BG;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_RMUL;
            end
          end else begin
            m_q     <= m_q + 1'b1;
            state_q <= S_RMUL;
          end
        end
        S_BG: begin
          k_q     <= '0;
          cum_q   <= '0;
          bacc_q  <= '0;
          fg_q    <= 1'b0;
          state_q <= S_BMUL;
        end
        S_BMUL: state_q <= S_BTHR;
        S_BTHR: begin
          bacc_q  <= bacc_q + gmbs_pkg::BACC_W'(acc_q[31:0]);
          cum_q   <= cum_q + gmbs_pkg::SUM_W'(wt_q[c]);
          state_q <= S_BCHK;
        end
        S_BCHK: begin
          if ({diff_q[c], 8'h00} <= acc_q[27:0]) begin
            fg_q <= 1'b1;
          end
          if ((cum_q >= gmbs_pkg::SUM_W'(cfg_i.frac)) || (k_q == LAST)) begin
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_BMUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_bg_q    <= (bacc_q[gmbs_pkg::BACC_W-1:32] != '0) ? 8'hFF : bacc_q[31:24];
            out_fg_q    <= ~fg_q;
            out_fp_q    <= fg_q ? 8'h00 : pix_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign background_pixel_o = out_bg_q;
  assign is_foreground_o    = out_fg_q;
  assign foreground_pixel_o = out_fp_q;

endmodule

// ----- rtl/gaussian_mixture_background_subtract.sv -----
// Each word is looked up, then updated component by component, taking longer the more
// of its four components match. The input queue holds up to two words while one is in
// work. Time per word is set by the shared 16-step divide/square-root unit and the one
// multiplier. Reset: asynchronous, active low; afterwards a sweep clears the per-pixel
// first-visit bits, during which no input word is taken (config writes still are).
module gaussian_mixture_background_subtract (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pixel_value_i,
  input  logic [15:0] pixel_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  background_pixel_o,
  output logic        is_foreground_o,
  output logic [7:0]  foreground_pixel_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  gmbs_pkg::cfg_t  cfg_q;
  logic            q_valid, q_pop;
  gmbs_pkg::item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha    <= gmbs_pkg::ALPHA_RST;
      cfg_q.dfac     <= gmbs_pkg::DFAC_RST;
      cfg_q.frac     <= gmbs_pkg::FRAC_RST;
      cfg_q.init_dev <= gmbs_pkg::INIT_DEV_RST;
    end else if (cfg_we_i) begin
      unique case (gmbs_pkg::cfg_reg_e'(cfg_index_i))
        gmbs_pkg::REG_ALPHA:    cfg_q.alpha    <= cfg_data_i;
        gmbs_pkg::REG_MATCH:    cfg_q.dfac     <= cfg_data_i[11:0];
        gmbs_pkg::REG_FRACTION: cfg_q.frac     <= cfg_data_i;
        gmbs_pkg::REG_INIT_DEV: cfg_q.init_dev <= cfg_data_i;
        default:                cfg_q          <= cfg_q;
      endcase
    end
  end

  gmbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .pixel_index_i (pixel_index_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  gmbs_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_valid_i          (q_valid),
    .q_item_i           (q_item),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .background_pixel_o (background_pixel_o),
    .is_foreground_o    (is_foreground_o),
    .foreground_pixel_o (foreground_pixel_o)
  );

`include "assert_macros.svh"

  `GMBS_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && !q_valid)
  `GMBS_ASSERT(a_accept_gap, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  `GMBS_ASSERT(a_bg_no_pix, clk_i, rst_ni, out_valid_o && !is_foreground_o |-> foreground_pixel_o == 8'd0)

endmodule

// ----- tb/gaussian_mixture_background_subtract_tb.sv -----
`timescale 1ns / 1ps

module gaussian_mixture_background_subtract_tb;

  localparam int NCOMP = 4;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [7:0] bg;
    logic       fg;
    logic [7:0] fg_pix;
  } pixel_result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [7:0]  pix;
    logic [15:0] idx;
    logic [15:0] alpha;
    logic [11:0] dfac;
    logic [15:0] frac;
    logic [15:0] init_dev;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  pixel_value_i = '0;
  logic [15:0] pixel_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  background_pixel_o;
  logic        is_foreground_o;
  logic [7:0]  foreground_pixel_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  gaussian_mixture_background_subtract uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] mix_mean [gmbs_pkg::PIXELS*NCOMP];
  logic [15:0] mix_dev  [gmbs_pkg::PIXELS*NCOMP];
  logic [15:0] mix_wt   [gmbs_pkg::PIXELS*NCOMP];
  bit          visited  [gmbs_pkg::PIXELS];
  logic [15:0] seed;
  logic [15:0] cur_alpha = gmbs_pkg::ALPHA_RST;
  logic [11:0] cur_dfac = gmbs_pkg::DFAC_RST;
  logic [15:0] cur_frac = gmbs_pkg::FRAC_RST;
  logic [15:0] cur_init_dev = gmbs_pkg::INIT_DEV_RST;

  pixel_result_t pending_results[$];
  int errors = 0;
  int idle_in = 0;
  int idle_out = 0;
  int hold_left = 0;
  bit hold_go = 0;
  int quiet_cycles = 0;

  function automatic logic [15:0] clamp_dev(input longint unsigned v);
    if (v == 0) return 16'd1;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic pixel_result_t mixture_update(input logic [7:0] pix,
                                                   input logic [15:0] idx);
    pixel_result_t r;
    int base, last, lo, a, b, c, t;
    int ord[NCOMP];
    longint unsigned x, w, p, nm, d, vr, rt, bt, sum, acc, cum, alpha;
    longint unsigned diff[NCOMP];
    bit any, fg_hit;
    base = int'(idx) * NCOMP;
    x = longint'(pix) << 8;
    alpha = cur_alpha;
    any = 0;
    fg_hit = 0;
    last = NCOMP - 1;
    sum = 0;
    acc = 0;
    cum = 0;
    if (!visited[idx]) begin
      for (int k = 0; k < NCOMP; k++) begin
        seed = seed[0] ? ((seed >> 1) ^ 16'hB400) : (seed >> 1);
        mix_mean[base+k] = seed;
        mix_dev[base+k] = clamp_dev(cur_init_dev);
        mix_wt[base+k] = 16'(65536 / NCOMP);
      end
      visited[idx] = 1;
    end
    for (int k = 0; k < NCOMP; k++)
      diff[k] = (x > mix_mean[base+k]) ? x - mix_mean[base+k] : mix_mean[base+k] - x;
    for (int k = 0; k < NCOMP; k++) begin
      if ((diff[k] << 8) < longint'(cur_dfac) * mix_dev[base+k]) begin
        any = 1;
        w = mix_wt[base+k];
        w = w + ((alpha * (65536 - w)) >> 16);
        if (w > 65535) w = 65535;
        mix_wt[base+k] = w[15:0];
        p = (w == 0) ? 65536 : (alpha << 16) / w;
        if (p > 65536) p = 65536;
        nm = ((65536 - p) * mix_mean[base+k] + p * x) >> 16;
        mix_mean[base+k] = nm[15:0];
        d = (x > nm) ? x - nm : nm - x;
        vr = ((65536 - p) * (longint'(mix_dev[base+k]) * mix_dev[base+k]) + p * (d * d)) >> 16;
        rt = 0;
        bt = 64'd1 << 62;
        while (bt > vr) bt = bt >> 2;
        while (bt != 0) begin
          if (vr >= rt + bt) begin
            vr = vr - (rt + bt);
            rt = (rt >> 1) + bt;
          end else begin
            rt = rt >> 1;
          end
          bt = bt >> 2;
        end
        mix_dev[base+k] = clamp_dev(rt);
      end else begin
        mix_wt[base+k] = 16'(((65536 - alpha) * mix_wt[base+k]) >> 16);
      end
    end
    if (!any) begin
      lo = 0;
      for (int k = 1; k < NCOMP; k++)
        if (mix_wt[base+k] < mix_wt[base+lo]) lo = k;
      mix_mean[base+lo] = x[15:0];
      mix_dev[base+lo] = clamp_dev(cur_init_dev);
    end
    for (int k = 0; k < NCOMP; k++) sum += mix_wt[base+k];
    for (int k = 0; k < NCOMP; k++) begin
      w = (sum == 0) ? 65536 / NCOMP : (longint'(mix_wt[base+k]) << 16) / sum;
      mix_wt[base+k] = (w > 65535) ? 16'hFFFF : w[15:0];
    end
    for (int k = 0; k < NCOMP; k++) ord[k] = k;
    for (int k = 1; k < NCOMP; k++) begin
      for (int m = 0; m < k; m++) begin
        a = ord[k];
        b = ord[m];
        if (longint'(mix_wt[base+a]) * mix_dev[base+b] >
            longint'(mix_wt[base+b]) * mix_dev[base+a]) begin
          ord[k] = b;
          ord[m] = a;
        end
      end
    end
    for (int k = 0; k < NCOMP; k++) begin
      c = ord[k];
      cum += mix_wt[base+c];
      acc += longint'(mix_mean[base+c]) * mix_wt[base+c];
      if (cum >= cur_frac) begin
        last = k;
        break;
      end
    end
    for (t = 0; t <= last && !fg_hit; t++) begin
      c = ord[t];
      if ((diff[c] << 8) <= longint'(cur_dfac) * mix_dev[base+c]) fg_hit = 1;
    end
    acc = acc >> 24;
    r.bg = (acc > 255) ? 8'hFF : acc[7:0];
    r.fg = !fg_hit;
    r.fg_pix = fg_hit ? 8'd0 : pix;
    return r;
  endfunction

  // scoreboard and watchdog
  always @(posedge clk_i) begin
    pixel_result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word bg=%0d fg=%0d fgpix=%0d", $time,
                   background_pixel_o, is_foreground_o, foreground_pixel_o);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (background_pixel_o !== e.bg) begin
            $display("%0t: background_pixel exp %0d got %0d", $time, e.bg,
                     background_pixel_o);
            errors++;
          end
          if (is_foreground_o !== e.fg) begin
            $display("%0t: is_foreground exp %0d got %0d", $time, e.fg, is_foreground_o);
            errors++;
          end
          if (foreground_pixel_o !== e.fg_pix) begin
            $display("%0t: foreground_pixel exp %0d got %0d", $time, e.fg_pix,
                     foreground_pixel_o);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        pending_results.push_back(mixture_update(pixel_value_i, pixel_index_i));
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_out);
    end
  end

  task automatic write_config(input logic [15:0] alpha, input logic [11:0] dfac,
                              input logic [15:0] frac, input logic [15:0] init_dev);
    cfg_we_i <= 1'b1;
    cfg_index_i <= gmbs_pkg::REG_ALPHA;
    cfg_data_i <= alpha;
    @(posedge clk_i);
    cfg_index_i <= gmbs_pkg::REG_MATCH;
    cfg_data_i <= {4'd0, dfac};
    @(posedge clk_i);
    cfg_index_i <= gmbs_pkg::REG_FRACTION;
    cfg_data_i <= frac;
    @(posedge clk_i);
    cfg_index_i <= gmbs_pkg::REG_INIT_DEV;
    cfg_data_i <= init_dev;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_alpha = alpha;
    cur_dfac = dfac;
    cur_frac = frac;
    cur_init_dev = init_dev;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_word(input logic [7:0] pix, input logic [15:0] idx);
    if ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_in);
    end
    in_valid_i <= 1'b1;
    pixel_value_i <= pix;
    pixel_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  logic [15:0] pool_idx [16];
  logic [7:0]  pool_bg  [16];

  task automatic random_phase(input int n);
    int s, v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        s = $urandom_range(15);
        if ($urandom_range(99) < 3) pool_bg[s] = 8'($urandom);
        if ($urandom_range(99) < 10) begin
          v = $urandom_range(255);
        end else begin
          v = int'(pool_bg[s]) + $urandom_range(12) - 6;
          v = (v < 0) ? 0 : (v > 255) ? 255 : v;
        end
        send_word(8'(v), pool_idx[s]);
      end else begin
        send_word(8'($urandom), 16'($urandom));
      end
    end
  endtask

  stim_row_t directed[] = '{
    '{1'b0, 8'd0,   16'h0000, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd255, 16'hFFFF, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd255, 16'hFFFF, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd128, 16'h5555, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd127, 16'hAAAA, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd0,   16'h0000, 16'd0, 12'd0, 16'd0, 16'd0},
    // wide deviation and factor: every component matches
    '{1'b1, 8'd0, 16'd0, 16'd655, 12'd4095, 16'd45875, 16'd65535},
    '{1'b0, 8'd100, 16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd100, 16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    // full-rate learning: deviation collapses to minimum
    '{1'b1, 8'd0, 16'd0, 16'd65535, 12'd4095, 16'd45875, 16'd65535},
    '{1'b0, 8'd100, 16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd100, 16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd100, 16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    // tight match: misses, weights decay to zero
    '{1'b1, 8'd0, 16'd0, 16'd65535, 12'd1, 16'd45875, 16'd256},
    '{1'b0, 8'd7,   16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd200, 16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd31,  16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b1, 8'd0, 16'd0, 16'd1, 12'd640, 16'd65535, 16'd1536},
    '{1'b0, 8'd50,  16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b0, 8'd90,  16'h0101, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b1, 8'd0, 16'd0, 16'd655, 12'd640, 16'd1, 16'd1536},
    '{1'b0, 8'd50,  16'h0100, 16'd0, 12'd0, 16'd0, 16'd0},
    '{1'b1, 8'd0, 16'd0, gmbs_pkg::ALPHA_RST, gmbs_pkg::DFAC_RST, gmbs_pkg::FRAC_RST,
      gmbs_pkg::INIT_DEV_RST}
  };

  initial begin
    seed = gmbs_pkg::LFSR_RESET;
    for (int i = 0; i < 16; i++) begin
      pool_idx[i] = 16'(i * 4099 + 7);
      pool_bg[i] = 8'($urandom);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        write_config(directed[i].alpha, directed[i].dfac, directed[i].frac,
                     directed[i].init_dev);
      end else begin
        send_word(directed[i].pix, directed[i].idx);
      end
    end
    drain();

    idle_in = 11;
    idle_out = 52;
    hold_go = 1;
    random_phase(320);
    drain();
    write_config(16'd3000, 12'd1024, 16'd60000, 16'd2048);

    idle_in = 52;
    idle_out = 11;
    random_phase(320);
    drain();
    write_config(16'd1, 12'd4095, 16'd1, 16'd256);

    idle_in = 0;
    idle_out = 0;
    random_phase(300);
    drain();

    if (errors == 0 && pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gmbs_pkg.sv
rtl/gmbs_ram.sv
rtl/gmbs_iter.sv
rtl/gmbs_front.sv
rtl/gmbs_back.sv
rtl/gaussian_mixture_background_subtract.sv
tb/gaussian_mixture_background_subtract_tb.sv
